[design/ddo_pkg.sv]
// shared types, constants and the quarter-wave sine table for the odometry block
// no dependencies; every other file imports this package
package ddo_pkg;

    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_AW = $clog2(SINE_ENTRIES);
    localparam int IDX_PROD_W = 30 + SINE_AW;

    localparam int TICK_W = 16;
    localparam int SUM_W = TICK_W + 1;
    localparam int SCALE_W = 24;
    localparam int POS_W = 32;
    localparam int ANGLE_W = 32;
    localparam int ROM_W = 16;
    localparam int TRIG_W = ROM_W + 2;
    localparam int P_W = SUM_W + SCALE_W;
    localparam int MUL_A_W = P_W;
    localparam int MUL_B_W = SCALE_W + 1;
    localparam int MUL_W = P_W + TRIG_W;
    localparam int ROUND_SHIFT = 25;
    localparam int DELTA_W = MUL_W - ROUND_SHIFT;
    localparam int POS_SUM_W = DELTA_W + 1;

    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    localparam int QUEUE_AW = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [ROM_W:0] TRIG_FULL = 17'h1_0000;
    localparam logic [MUL_W-1:0] ROUND_HALF = MUL_W'(64'd1 << (ROUND_SHIFT - 1));
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    localparam logic [SCALE_W-1:0] DIST_SCALE_RESET = 24'd100657;
    localparam logic [SCALE_W-1:0] TURN_SCALE_RESET = 24'd781180;

    typedef enum logic [2:0] {
        REG_DISTANCE_SCALE = 3'd0,
        REG_TURN_SCALE     = 3'd1,
        REG_START_X        = 3'd2,
        REG_START_Y        = 3'd3,
        REG_START_HEADING  = 3'd4,
        REG_TARGET_Y       = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_TURN,
        BK_DX,
        BK_DY,
        BK_FIN
    } t_back_state;

    typedef struct packed {
        logic signed [TICK_W-1:0] right_ticks;
        logic signed [TICK_W-1:0] left_ticks;
        logic                     restart;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [ANGLE_W-1:0]      heading;
        logic                    reached;
        logic                    saturated;
    } t_out_item;

    typedef struct packed {
        logic [SCALE_W-1:0]      distance_scale;
        logic [SCALE_W-1:0]      turn_scale;
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic [ANGLE_W-1:0]      start_heading;
        logic signed [POS_W-1:0] target_y;
    } t_cfg;

    typedef struct packed {
        logic                    restart;
        logic signed [SUM_W-1:0] tick_sum;
        logic signed [SUM_W-1:0] tick_diff;
    } t_job;

    typedef struct packed {
        logic [SINE_AW-1:0] addr;
        logic               full;
        logic               neg;
    } t_trig_ref;

    typedef logic [ROM_W-1:0] t_sine_table [SINE_ENTRIES];

    localparam logic [63:0] HALF_PI_Q30 = 64'h6487_ED51;
    localparam logic [63:0] Q30_HALF = 64'h2000_0000;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    // sine of a q2.30 angle in the first quadrant, q2.30 result
    function automatic logic [63:0] taylor_sin(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        x2 = (x * x) >> 30;
        term = x;
        s = x;
        for (int k = 0; k < 6; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k[0]) begin
                s = s + term;
            end else begin
                s = s - term;
            end
        end
        return s;
    endfunction

    function automatic t_sine_table build_sine_table();
        t_sine_table tab;
        logic [63:0] ang;
        logic [63:0] v;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            ang = (HALF_PI_Q30 * 64'(i) + 64'(SINE_ENTRIES / 2)) / 64'(SINE_ENTRIES);
            v = (taylor_sin(ang) * 64'd65536 + Q30_HALF) >> 30;
            tab[i] = (v > 64'd65535) ? 16'hFFFF : v[ROM_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_table SINE_TABLE = build_sine_table();

endpackage

[design/differential_drive_odometry.sv]
// differential-drive wheel odometry, top level
// depends on ddo_pkg, ddo_cfg, ddo_front and ddo_back
//
// Each input beat carries the signed tick changes of both wheels for one sample
// period, or a restart flag that reloads the start pose; each beat yields exactly
// one result beat with x, y (Q16.16, saturating), the binary-angle heading, a
// target-reached flag and a clip flag. A two-entry job queue sits between the
// input side and the pose sequencer, so input beats are taken while earlier ones
// are still being worked on and a finished result waits in its own output
// register. An update beat takes the job, runs four products through the single
// shared 41x25 multiplier interleaved with two single-port sine table reads and
// finishes; a restart beat goes straight to the finish. Registers must be
// written over the APB-style port while no beat is in flight (not enforced).
module differential_drive_odometry (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ddo_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ddo_pkg::t_out_item         o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ddo_pkg::CFG_AW-1:0] paddr,
    input  logic [ddo_pkg::CFG_DW-1:0] pwdata,
    output logic [ddo_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);
    import ddo_pkg::*;

    t_cfg w_cfg;
    t_job w_job;
    logic w_job_valid;
    logic w_job_pop;

    ddo_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ddo_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    ddo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[design/ddo_cfg.sv]
// configuration register bank behind the apb-style port
// depends on ddo_pkg
module ddo_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ddo_pkg::CFG_AW-1:0] paddr,
    input  logic [ddo_pkg::CFG_DW-1:0] pwdata,
    output logic [ddo_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output ddo_pkg::t_cfg              o_cfg
);
    import ddo_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign w_wr = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.distance_scale <= DIST_SCALE_RESET;
            r_cfg.turn_scale <= TURN_SCALE_RESET;
            r_cfg.start_x <= '0;
            r_cfg.start_y <= '0;
            r_cfg.start_heading <= '0;
            r_cfg.target_y <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_DISTANCE_SCALE: r_cfg.distance_scale <= pwdata[SCALE_W-1:0];
                REG_TURN_SCALE:     r_cfg.turn_scale <= pwdata[SCALE_W-1:0];
                REG_START_X:        r_cfg.start_x <= pwdata;
                REG_START_Y:        r_cfg.start_y <= pwdata;
                REG_START_HEADING:  r_cfg.start_heading <= pwdata;
                REG_TARGET_Y:       r_cfg.target_y <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DISTANCE_SCALE: prdata = CFG_DW'(r_cfg.distance_scale);
            REG_TURN_SCALE:     prdata = CFG_DW'(r_cfg.turn_scale);
            REG_START_X:        prdata = r_cfg.start_x;
            REG_START_Y:        prdata = r_cfg.start_y;
            REG_START_HEADING:  prdata = r_cfg.start_heading;
            REG_TARGET_Y:       prdata = r_cfg.target_y;
            default:            prdata = '0;
        endcase
    end

endmodule

[design/ddo_front.sv]
// front end: accepts tick beats, forms tick sum and difference, queues the jobs
// depends on ddo_pkg
module ddo_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ddo_pkg::t_in_item i_in_data,
    output logic              o_job_valid,
    output ddo_pkg::t_job     o_job,
    input  logic              i_job_pop
);
    import ddo_pkg::*;

    t_job                r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    t_job                w_job;
    logic                w_push;
    logic                w_pop;

    always_comb begin
        w_job.restart = i_in_data.restart;
        w_job.tick_sum = {i_in_data.right_ticks[TICK_W-1], i_in_data.right_ticks}
                       + {i_in_data.left_ticks[TICK_W-1], i_in_data.left_ticks};
        w_job.tick_diff = {i_in_data.right_ticks[TICK_W-1], i_in_data.right_ticks}
                        - {i_in_data.left_ticks[TICK_W-1], i_in_data.left_ticks};
    end

    assign o_in_stall = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job = r_queue[r_rd_ptr];
    assign w_push = i_in_valid & ~o_in_stall;
    assign w_pop = i_job_pop & o_job_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/ddo_back.sv]
// back end: pose sequencer with one shared multiplier and the sine rom
// depends on ddo_pkg
module ddo_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ddo_pkg::t_cfg      i_cfg,
    input  logic               i_job_valid,
    input  ddo_pkg::t_job      i_job,
    output logic               o_job_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ddo_pkg::t_out_item o_out_data
);
    import ddo_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic                      r_restart;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [SUM_W-1:0]   r_diff;
    logic signed [MUL_W-1:0]   r_prod;
    logic signed [P_W-1:0]     r_p;
    logic [ANGLE_W-1:0]        r_turn;
    logic signed [TRIG_W-1:0]  r_cos;
    logic signed [TRIG_W-1:0]  r_sin;
    logic                      r_ref_full;
    logic                      r_ref_neg;
    logic [ROM_W-1:0]          r_rom_q;
    logic signed [POS_W-1:0]   r_x;
    logic signed [POS_W-1:0]   r_y;
    logic [ANGLE_W-1:0]        r_heading;
    logic                      r_sat;
    t_out_item                 r_out;
    logic                      r_out_valid;

    t_trig_ref                        w_cos_ref;
    t_trig_ref                        w_sin_ref;
    logic [SINE_AW-1:0]               w_rom_addr;
    logic [ROM_W:0]                   w_mag;
    logic signed [TRIG_W-1:0]         w_trig;
    logic signed [MUL_A_W-1:0]        w_mul_a;
    logic signed [MUL_B_W-1:0]        w_mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] w_mul_full;
    logic [MUL_W-1:0]                 w_round;
    logic signed [DELTA_W-1:0]        w_delta;
    logic signed [POS_SUM_W-1:0]      w_x_sum;
    logic signed [POS_SUM_W-1:0]      w_y_sum;
    logic signed [POS_W-1:0]          w_x_clip;
    logic signed [POS_W-1:0]          w_y_clip;
    logic                             w_x_sat;
    logic                             w_y_sat;
    logic signed [POS_W-1:0]          w_y_fin;
    logic                             w_load;

    // quadrant folding of a binary angle onto the quarter-wave table
    function automatic t_trig_ref trig_ref(input logic [ANGLE_W-1:0] a);
        t_trig_ref           r;
        logic [IDX_PROD_W-1:0] prod;
        logic [SINE_AW-1:0]  idx;
        logic [SINE_AW:0]    mirror;
        prod = IDX_PROD_W'(a[29:0]) * IDX_PROD_W'(SINE_ENTRIES);
        idx = prod[IDX_PROD_W-1:30];
        mirror = (SINE_AW + 1)'(SINE_ENTRIES) - {1'b0, idx};
        r.neg = a[31];
        if (a[30]) begin
            r.full = (idx == '0);
            r.addr = mirror[SINE_AW-1:0];
        end else begin
            r.full = 1'b0;
            r.addr = idx;
        end
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] clip_pos(
        input logic signed [POS_SUM_W-1:0] v
    );
        logic ovf;
        ovf = (v[POS_SUM_W-1:POS_W-1] != '0) && (v[POS_SUM_W-1:POS_W-1] != '1);
        if (!ovf) begin
            return v[POS_W-1:0];
        end else if (v[POS_SUM_W-1]) begin
            return POS_MIN;
        end else begin
            return POS_MAX;
        end
    endfunction

    assign w_cos_ref = trig_ref(r_heading + QUARTER_TURN);
    assign w_sin_ref = trig_ref(r_heading);
    assign w_rom_addr = (r_state == BK_LOAD) ? w_cos_ref.addr : w_sin_ref.addr;

    always_ff @(posedge i_clk) begin
        r_rom_q <= SINE_TABLE[w_rom_addr];
    end

    assign w_mag = r_ref_full ? TRIG_FULL : {1'b0, r_rom_q};
    assign w_trig = r_ref_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});

    // shared multiplier: travel, turn, then travel against cosine and sine
    always_comb begin
        case (r_state)
            BK_LOAD: begin
                w_mul_a = {{(MUL_A_W-SUM_W){r_sum[SUM_W-1]}}, r_sum};
                w_mul_b = {1'b0, i_cfg.distance_scale};
            end
            BK_TURN: begin
                w_mul_a = {{(MUL_A_W-SUM_W){r_diff[SUM_W-1]}}, r_diff};
                w_mul_b = {1'b0, i_cfg.turn_scale};
            end
            BK_DX: begin
                w_mul_a = r_p;
                w_mul_b = {{(MUL_B_W-TRIG_W){r_cos[TRIG_W-1]}}, r_cos};
            end
            default: begin
                w_mul_a = r_p;
                w_mul_b = {{(MUL_B_W-TRIG_W){r_sin[TRIG_W-1]}}, r_sin};
            end
        endcase
    end

    assign w_mul_full = w_mul_a * w_mul_b;

    // round half up then floor shift
    assign w_round = r_prod + ROUND_HALF;
    assign w_delta = w_round[MUL_W-1:ROUND_SHIFT];
    assign w_x_sum = {{(POS_SUM_W-POS_W){r_x[POS_W-1]}}, r_x}
                   + {{(POS_SUM_W-DELTA_W){w_delta[DELTA_W-1]}}, w_delta};
    assign w_y_sum = {{(POS_SUM_W-POS_W){r_y[POS_W-1]}}, r_y}
                   + {{(POS_SUM_W-DELTA_W){w_delta[DELTA_W-1]}}, w_delta};
    assign w_x_clip = clip_pos(w_x_sum);
    assign w_y_clip = clip_pos(w_y_sum);
    assign w_x_sat = (w_x_clip != w_x_sum[POS_W-1:0]);
    assign w_y_sat = (w_y_clip != w_y_sum[POS_W-1:0]);
    assign w_y_fin = r_restart ? r_y : w_y_clip;
    assign w_load = (r_state == BK_FIN) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        o_job_pop = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_state = i_job.restart ? BK_FIN : BK_LOAD;
                end
            end
            BK_LOAD: n_state = BK_TURN;
            BK_TURN: n_state = BK_DX;
            BK_DX:   n_state = BK_DY;
            BK_DY:   n_state = BK_FIN;
            BK_FIN: begin
                if (w_load) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_full[MUL_W-1:0];
        case (r_state)
            BK_IDLE: begin
                r_restart <= i_job.restart;
                r_sum <= i_job.tick_sum;
                r_diff <= i_job.tick_diff;
                r_sat <= 1'b0;
            end
            BK_LOAD: begin
                r_ref_full <= w_cos_ref.full;
                r_ref_neg <= w_cos_ref.neg;
            end
            BK_TURN: begin
                r_p <= r_prod[P_W-1:0];
                r_cos <= w_trig;
                r_ref_full <= w_sin_ref.full;
                r_ref_neg <= w_sin_ref.neg;
            end
            BK_DX: begin
                r_turn <= r_prod[ANGLE_W-1:0];
                r_sin <= w_trig;
            end
            BK_DY: begin
                r_sat <= w_x_sat;
            end
            default: ;
        endcase
        if (w_load) begin
            r_out.pos_x <= r_x;
            r_out.pos_y <= w_y_fin;
            r_out.heading <= r_heading;
            r_out.reached <= (w_y_fin > i_cfg.target_y);
            r_out.saturated <= r_sat | (~r_restart & w_y_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
            r_heading <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == BK_IDLE && i_job_valid && i_job.restart) begin
                r_x <= i_cfg.start_x;
                r_y <= i_cfg.start_y;
                r_heading <= i_cfg.start_heading;
            end
            if (r_state == BK_DY) begin
                r_x <= w_x_clip;
                r_heading <= r_heading + r_turn;
            end
            if (w_load) begin
                r_y <= w_y_fin;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    // a fresh result only ever comes out of the final step
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == BK_FIN)
        else $error("result raised outside final step");

    // a restart beat puts the start pose straight into the accumulators
    a_restart_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_IDLE && i_job_valid && i_job.restart)
        |=> (r_x == $past(i_cfg.start_x)) && (r_heading == $past(i_cfg.start_heading)))
        else $error("restart did not load start pose");

    // a clipped flag implies some coordinate sits at a limit
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.saturated)
        |-> (r_out.pos_x == POS_MAX) || (r_out.pos_x == POS_MIN)
            || (r_out.pos_y == POS_MAX) || (r_out.pos_y == POS_MIN))
        else $error("saturated result away from limits");

endmodule

[bench/differential_drive_odometry_tb.sv]
// self-checking bench for differential_drive_odometry: directed table, then random beats
// depends on ddo_pkg and the block; predicts every pose with its own integrator and sine table
module differential_drive_odometry_tb;
    import ddo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES = 24;
    localparam int MAX_PRINT = 40;
    localparam int PHASE_BEATS = 125;
    localparam logic [2:0] UNMAPPED_REG = 3'd6;
    localparam logic [31:0] QTR_TURN = 32'h4000_0000;
    localparam longint POSE_HI = 64'sd2147483647;
    localparam longint POSE_LO = -POSE_HI - 64'sd1;

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [31:0] val;
        t_in_item    beat;
        logic        typed;
        t_out_item   want;
    } stim_row_t;

    // default registers until the first write rows
    localparam stim_row_t STIM_TABLE [37] = '{
        '{ROW_BEAT, '0, '0, '{16'sh7FFF, 16'sh8000, 1'b1}, 1'b1, '0},
        '{ROW_BEAT, '0, '0, '{16'sh0000, 16'sh0000, 1'b0}, 1'b1, '0},
        '{ROW_BEAT, '0, '0, '{16'sh7FFF, 16'sh7FFF, 1'b0}, 1'b0, '0},
        '{ROW_BEAT, '0, '0, '{16'sh8000, 16'sh8000, 1'b0}, 1'b0, '0},
        '{ROW_BEAT, '0, '0, '{16'sh7FFF, 16'sh8000, 1'b0}, 1'b0, '0},
        '{ROW_BEAT, '0, '0, '{16'sh8000, 16'sh7FFF, 1'b0}, 1'b0, '0},
        '{ROW_BEAT, '0, '0, '{16'sh0001, 16'sh0000, 1'b0}, 1'b0, '0},
        '{ROW_BEAT, '0, '0, '{16'sh0000, 16'shFFFF, 1'b0}, 1'b0, '0},
        '{ROW_BEAT, '0, '0, '{16'sh5555, 16'shAAAA, 1'b0}, 1'b0, '0},
        '{ROW_BEAT, '0, '0, '{16'shAAAA, 16'sh5555, 1'b0}, 1'b0, '0},
        '{ROW_REG, REG_DISTANCE_SCALE, 32'hFFFF_FFFF, '0, 1'b0, '0},
        '{ROW_REG, REG_TURN_SCALE, 32'h0000_0000, '0, 1'b0, '0},
        '{ROW_REG, REG_START_X, 32'h7FFF_0000, '0, 1'b0, '0},
        '{ROW_REG, REG_START_Y, 32'h0001_0000, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, '{16'sh0000, 16'sh0000, 1'b1}, 1'b1,
          '{32'sh7FFF_0000, 32'sh0001_0000, 32'h0000_0000, 1'b1, 1'b0}},
        // full-speed forward at heading zero clips x high
        '{ROW_BEAT, '0, '0, '{16'sh7FFF, 16'sh7FFF, 1'b0}, 1'b1,
          '{32'sh7FFF_FFFF, 32'sh0001_0000, 32'h0000_0000, 1'b1, 1'b1}},
        '{ROW_REG, REG_START_X, 32'h8001_0000, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, '{16'sh1234, 16'sh4321, 1'b1}, 1'b1,
          '{32'sh8001_0000, 32'sh0001_0000, 32'h0000_0000, 1'b1, 1'b0}},
        '{ROW_BEAT, '0, '0, '{16'sh8000, 16'sh8000, 1'b0}, 1'b1,
          '{32'sh8000_0000, 32'sh0001_0000, 32'h0000_0000, 1'b1, 1'b1}},
        '{ROW_REG, REG_START_Y, 32'h7FFF_0000, '0, 1'b0, '0},
        '{ROW_REG, REG_START_HEADING, 32'h4000_0000, '0, 1'b0, '0},
        '{ROW_REG, REG_TARGET_Y, 32'h7FFF_FFFF, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, '{16'sh0000, 16'sh0000, 1'b1}, 1'b1,
          '{32'sh8001_0000, 32'sh7FFF_0000, 32'h4000_0000, 1'b0, 1'b0}},
        // quarter turn: travel goes into y, which clips high
        '{ROW_BEAT, '0, '0, '{16'sh7FFF, 16'sh7FFF, 1'b0}, 1'b1,
          '{32'sh8001_0000, 32'sh7FFF_FFFF, 32'h4000_0000, 1'b0, 1'b1}},
        '{ROW_REG, REG_START_Y, 32'h8001_0000, '0, 1'b0, '0},
        '{ROW_REG, REG_START_HEADING, 32'hC000_0000, '0, 1'b0, '0},
        '{ROW_REG, REG_TARGET_Y, 32'h8000_0000, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, '{16'sh0000, 16'sh0000, 1'b1}, 1'b1,
          '{32'sh8001_0000, 32'sh8001_0000, 32'hC000_0000, 1'b1, 1'b0}},
        '{ROW_BEAT, '0, '0, '{16'sh7FFF, 16'sh7FFF, 1'b0}, 1'b1,
          '{32'sh8001_0000, 32'sh8000_0000, 32'hC000_0000, 1'b0, 1'b1}},
        '{ROW_REG, UNMAPPED_REG, 32'hDEAD_BEEF, '0, 1'b0, '0},
        '{ROW_REG, REG_TURN_SCALE, 32'hFFFF_FFFF, '0, 1'b0, '0},
        '{ROW_REG, REG_DISTANCE_SCALE, 32'h0000_0000, '0, 1'b0, '0},
        // spin on the spot until the heading wraps
        '{ROW_BEAT, '0, '0, '{16'sh7FFF, 16'sh8000, 1'b0}, 1'b0, '0},
        '{ROW_BEAT, '0, '0, '{16'sh7FFF, 16'sh8000, 1'b0}, 1'b0, '0},
        '{ROW_BEAT, '0, '0, '{16'sh7FFF, 16'sh8000, 1'b0}, 1'b0, '0},
        '{ROW_REG, REG_START_X, 32'h1234_5678, '0, 1'b0, '0},
        '{ROW_BEAT, '0, '0, '{16'sh0000, 16'sh0000, 1'b0}, 1'b0, '0}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                o_in_stall;
    t_in_item            in_data;
    logic                o_out_valid;
    logic                out_stall;
    t_out_item           o_out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    // predictor state and register mirror
    logic [15:0]         quarter_wave [SINE_ENTRIES];
    longint              pose_x;
    longint              pose_y;
    logic [31:0]         pose_hdg;
    logic [23:0]         cfg_dist;
    logic [23:0]         cfg_turn;
    logic signed [31:0]  cfg_sx;
    logic signed [31:0]  cfg_sy;
    logic [31:0]         cfg_sh;
    logic signed [31:0]  cfg_ty;

    t_out_item           pose_queue [$];
    int                  mismatches;
    int                  result_count;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    differential_drive_odometry uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINT) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            flag($sformatf("result %0d %s: got %h, want %h", result_count, name, got, want));
        end
    endtask

    // q1.16 sine of a binary angle from the quarter-wave table
    function automatic longint wave_q16(logic [31:0] ang);
        longint idx;
        longint j;
        longint mag;
        idx = (longint'(ang[29:0]) * SINE_ENTRIES) >>> 30;
        j = ang[30] ? SINE_ENTRIES - idx : idx;
        mag = (j >= SINE_ENTRIES) ? 64'sd65536 : longint'(quarter_wave[j]);
        return ang[31] ? -mag : mag;
    endfunction

    function automatic longint clamp_pose(longint v, inout logic hit);
        if (v > POSE_HI) begin
            hit = 1'b1;
            return POSE_HI;
        end
        if (v < POSE_LO) begin
            hit = 1'b1;
            return POSE_LO;
        end
        return v;
    endfunction

    function automatic t_out_item advance_pose(t_in_item beat);
        longint span;
        longint dx;
        longint dy;
        logic [63:0] spin;
        logic clipped;
        t_out_item res;
        clipped = 1'b0;
        if (beat.restart) begin
            pose_x = longint'(cfg_sx);
            pose_y = longint'(cfg_sy);
            pose_hdg = cfg_sh;
        end else begin
            span = (longint'(beat.right_ticks) + longint'(beat.left_ticks))
                   * longint'(cfg_dist);
            // half travel times trig, rounded to nearest q16.16
            dx = (span * wave_q16(pose_hdg + QTR_TURN) + (64'sd1 <<< 24)) >>> 25;
            dy = (span * wave_q16(pose_hdg) + (64'sd1 <<< 24)) >>> 25;
            spin = (longint'(beat.right_ticks) - longint'(beat.left_ticks))
                   * longint'(cfg_turn);
            pose_x = clamp_pose(pose_x + dx, clipped);
            pose_y = clamp_pose(pose_y + dy, clipped);
            pose_hdg = pose_hdg + spin[31:0];
        end
        res.pos_x = pose_x[31:0];
        res.pos_y = pose_y[31:0];
        res.heading = pose_hdg;
        res.reached = pose_y > longint'(cfg_ty);
        res.saturated = clipped;
        return res;
    endfunction

    function automatic void mirror_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_DISTANCE_SCALE: cfg_dist = val[23:0];
            REG_TURN_SCALE:     cfg_turn = val[23:0];
            REG_START_X:        cfg_sx = val;
            REG_START_Y:        cfg_sy = val;
            REG_START_HEADING:  cfg_sh = val;
            REG_TARGET_Y:       cfg_ty = val;
            default: ;
        endcase
    endfunction

    // all tasks below start and end at a falling edge
    task automatic push_beat(t_in_item beat, logic typed, t_out_item typed_res);
        t_out_item res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        res = advance_pose(beat);
        pose_queue.push_back(typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (pose_queue.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'({idx, 2'b00});
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        mirror_reg(idx, val);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] next_ticks();
        case ($urandom_range(0, 9))
            6, 7:    return 16'($urandom);
            8:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            9:       return 16'sh0000;
            default: return 16'(int'($urandom_range(0, 600)) - 300);
        endcase
    endfunction

    // result side stalls at the phase's rate
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall) begin
            result_count++;
            if (pose_queue.size() == 0) begin
                flag($sformatf("result %0d arrived with none expected", result_count));
            end else begin
                want = pose_queue.pop_front();
                check_field("pos_x", o_out_data.pos_x, want.pos_x);
                check_field("pos_y", o_out_data.pos_y, want.pos_y);
                check_field("heading", o_out_data.heading, want.heading);
                check_field("reached", 32'(o_out_data.reached), 32'(want.reached));
                check_field("saturated", 32'(o_out_data.saturated), 32'(want.saturated));
            end
        end
    end

    // ends the run if no beat, no result and no register write goes through for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                    || (psel && penable && pwrite && pready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [63:0] ang;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] v;
        logic [31:0] ds;
        logic [31:0] ts;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sh;
        logic [31:0] ty;
        stim_row_t row;
        t_in_item beat;

        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        result_count = 0;
        send_idle_pct = 28;
        recv_idle_pct = 59;

        // quarter-wave sine, taylor series to the 13th power
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            ang = (64'h6487_ED51 * 64'(i) + 64'(SINE_ENTRIES / 2)) / 64'(SINE_ENTRIES);
            x2 = (ang * ang) >> 30;
            term = ang;
            acc = ang;
            for (int k = 0; k < 6; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k + 2) * (2 * k + 3));
                acc = (k % 2 == 1) ? acc + term : acc - term;
            end
            v = (acc * 64'd65536 + (64'd1 << 29)) >> 30;
            quarter_wave[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
        end

        pose_x = 0;
        pose_y = 0;
        pose_hdg = '0;
        cfg_dist = 24'd100657;
        cfg_turn = 24'd781180;
        cfg_sx = '0;
        cfg_sy = '0;
        cfg_sh = '0;
        cfg_ty = '0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < $size(STIM_TABLE); r++) begin
            row = STIM_TABLE[r];
            if (row.kind == ROW_REG) begin
                settle_block();
                write_reg(row.idx, row.val);
            end else begin
                push_beat(row.beat, row.typed, row.want);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 59 : 0;
            recv_idle_pct = (ph < 2) ? 59 : (ph < 4) ? 28 : 0;
            case (ph)
                1: begin
                    ds = 32'h0;
                    ts = 32'h00FF_FFFF;
                    sx = 32'h7FFF_FFFF;
                    sy = 32'h8000_0000;
                    sh = 32'hFFFF_FFFF;
                    ty = 32'h8000_0000;
                end
                2: begin
                    ds = 32'hFFFF_FFFF;
                    ts = 32'h0;
                    sx = 32'h8000_0000;
                    sy = 32'h7FFF_FFFF;
                    sh = 32'h0;
                    ty = 32'h7FFF_FFFF;
                end
                default: begin
                    ds = (ph == 3) ? $urandom : $urandom_range(32768, 262143);
                    ts = $urandom;
                    sx = $urandom;
                    sy = $urandom;
                    sh = $urandom;
                    ty = $urandom;
                end
            endcase
            settle_block();
            write_reg(REG_DISTANCE_SCALE, ds);
            write_reg(REG_TURN_SCALE, ts);
            write_reg(REG_START_X, sx);
            write_reg(REG_START_Y, sy);
            write_reg(REG_START_HEADING, sh);
            write_reg(REG_TARGET_Y, ty);
            write_reg(UNMAPPED_REG, $urandom);

            // every phase opens from its start pose
            beat.right_ticks = 16'($urandom);
            beat.left_ticks = 16'($urandom);
            beat.restart = 1'b1;
            push_beat(beat, 1'b0, '0);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                beat.right_ticks = next_ticks();
                beat.left_ticks = ($urandom_range(0, 3) == 0) ? beat.right_ticks
                                                              : next_ticks();
                beat.restart = ($urandom_range(0, 99) < 4);
                push_beat(beat, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pose_queue.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
